// ===== rtl/core/b64c_pkg.sv =====
// Shared types, character codes and alphabet helpers for the Base64 codec.
`default_nettype none

package b64c_pkg;

  localparam int unsigned RunLen = 5;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_input;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
  } out_item_t;

  // all results caused by one input beat
  typedef struct packed {
    logic [RunLen-1:0][7:0] bytes;
    logic [2:0]             count;
  } run_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // map a 6-bit value onto the alphabet A-Z a-z 0-9 + /
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // map an alphabet character back to its 6-bit value; ok low for anything else
  function automatic sextet_t dec_char(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_codec_unit.sv =====
// Top level of the streaming Base64 encoder / decoder.
//
// Usage:
//   Input channel in_valid/in_ready/in_item carries one byte (or a bare end
//   marker) per beat; end_of_input flushes the partial group. Output channel
//   out_valid/out_ready/out_item carries one character or byte per beat, with
//   last_in_run marking the final result caused by an input beat. cfg_we/cfg_wdata write
//   the mode (0 encode, 1 decode); the user does so only while the block idles, unchecked by the block.
// Timing: the first result of an input beat is offered the cycle after the
//   beat is accepted when no run is draining; the rest follow one per cycle
//   while out_ready is high. Throughput: an input beat is taken every cycle
//   while the output keeps up; each beat yields 0 to 5 results and the
//   output moves one per cycle under the same condition; a beat that flushes
//   a partial group with its newline yields five results.
// Stall: a draining run register plus one pending run register sit between
//   the two sides; beats with no result keep being taken, one beat with
//   results parks in the pending register, and then in_ready drops until the
//   receiver takes the last result of the draining run.
// Reset: synchronous rst clears the mode to encode, the group count, the
//   halt flag, the output position and the valid flags of both run registers.
`default_nettype none

module base64_codec_unit (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire                   cfg_wdata,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  b64c_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  wire                   out_ready,
  output b64c_pkg::out_item_t   out_item
);

  // configuration and group state
  logic             mode;
  logic [7:0]       store [3];
  logic [1:0]       fill;
  logic [1:0]       fill_next;
  logic             halted;
  logic             halted_next;
  logic             store_we;
  logic [1:0]       store_idx;

  // run registers
  b64c_pkg::run_t   run_new;
  b64c_pkg::run_t   cur_run;
  b64c_pkg::run_t   pend_run;
  logic             cur_valid;
  logic             pend_valid;
  logic [2:0]       cur_pos;

  logic             accept;
  logic             cur_last;
  logic             cur_done;
  logic             cur_free;

  // encode datapath
  logic [1:0]       enc_fill;
  logic [7:0]       e0, e1, e2, eb1, eb2;
  logic [1:0]       enc_cnt;
  logic             enc_full;
  logic             enc_emit;
  logic [7:0]       c0, c1, c2, c3;

  // decode datapath
  logic             take;
  logic             dec_full;
  logic [7:0]       d0, d1, d2, d3;
  logic [2:0]       dec_cnt;
  logic             dec_emit;
  b64c_pkg::sextet_t s0, s1, s2, s3;
  logic             ok01, bad01, use2, bad2, p1, use3, p2, bad3, halt_set;
  logic [5:0]       v2z;
  logic [7:0]       y0, y1, y2;

  assign accept   = in_valid && in_ready;
  assign in_ready = !pend_valid;

  // build the run of results for the beat on the input
  always_comb begin
    run_new     = '0;
    fill_next   = fill;
    halted_next = halted;
    store_we    = 1'b0;
    store_idx   = 2'd0;

    // encode: clamp a full count left over from decode mode
    enc_fill = (fill == 2'd3) ? 2'd2 : fill;
    e0 = (in_item.has_byte && enc_fill == 2'd0) ? in_item.data_byte : store[0];
    e1 = (in_item.has_byte && enc_fill == 2'd1) ? in_item.data_byte : store[1];
    e2 = (in_item.has_byte && enc_fill == 2'd2) ? in_item.data_byte : store[2];
    enc_cnt  = in_item.has_byte ? enc_fill + 2'd1 : fill;
    enc_full = in_item.has_byte && enc_cnt == 2'd3;
    enc_emit = enc_full || (in_item.end_of_input && enc_cnt != 2'd0);
    eb1 = (enc_cnt > 2'd1) ? e1 : 8'd0;
    eb2 = (enc_cnt > 2'd2) ? e2 : 8'd0;
    c0  = b64c_pkg::enc_char(e0[7:2]);
    c1  = b64c_pkg::enc_char({e0[1:0], eb1[7:4]});
    c2  = (enc_cnt > 2'd1) ? b64c_pkg::enc_char({eb1[3:0], eb2[7:6]})
                           : b64c_pkg::PAD_CHAR;
    c3  = (enc_cnt > 2'd2) ? b64c_pkg::enc_char(eb2[5:0]) : b64c_pkg::PAD_CHAR;

    // decode: gather the group with the new character in place
    take     = in_item.has_byte && !halted;
    dec_full = take && fill == 2'd3;
    d0 = (take && fill == 2'd0) ? in_item.data_byte : store[0];
    d1 = (take && fill == 2'd1) ? in_item.data_byte : store[1];
    d2 = (take && fill == 2'd2) ? in_item.data_byte : store[2];
    d3 = in_item.data_byte;
    dec_cnt  = dec_full ? 3'd4 : (take ? {1'b0, fill} + 3'd1 : {1'b0, fill});
    dec_emit = dec_full || (in_item.end_of_input && !halted && dec_cnt != 3'd0);
    s0 = b64c_pkg::dec_char(d0);
    s1 = b64c_pkg::dec_char(d1);
    s2 = b64c_pkg::dec_char(d2);
    s3 = b64c_pkg::dec_char(d3);
    ok01  = dec_cnt >= 3'd2 && s0.ok && s1.ok;
    bad01 = dec_cnt >= 3'd2 && !(s0.ok && s1.ok);
    use2  = dec_cnt >= 3'd3 && d2 != b64c_pkg::PAD_CHAR;
    bad2  = ok01 && use2 && !s2.ok;
    p1    = ok01 && use2 && s2.ok;
    use3  = dec_cnt == 3'd4 && d3 != b64c_pkg::PAD_CHAR;
    p2    = ok01 && !bad2 && use3 && s3.ok;
    bad3  = ok01 && !bad2 && use3 && !s3.ok;
    halt_set = dec_emit && (bad01 || bad2 || bad3);
    v2z = use2 ? s2.val : 6'd0;
    y0  = {s0.val, s1.val[5:4]};
    y1  = {s1.val[3:0], s2.val[5:2]};
    y2  = {v2z[1:0], s3.val};

    if (mode == b64c_pkg::MODE_ENCODE) begin
      if (enc_emit) begin
        run_new.bytes[0] = c0;
        run_new.bytes[1] = c1;
        run_new.bytes[2] = c2;
        run_new.bytes[3] = c3;
        run_new.bytes[4] = b64c_pkg::NEWLINE_CHAR;
        run_new.count    = in_item.end_of_input ? 3'd5 : 3'd4;
      end else begin
        run_new.bytes[0] = b64c_pkg::NEWLINE_CHAR;
        run_new.count    = in_item.end_of_input ? 3'd1 : 3'd0;
      end
      fill_next   = (in_item.end_of_input || enc_full) ? 2'd0 : enc_cnt;
      halted_next = in_item.end_of_input ? 1'b0 : halted;
      store_we    = in_item.has_byte;
      store_idx   = enc_fill;
    end else begin
      run_new.bytes[0] = y0;
      run_new.bytes[1] = p1 ? y1 : y2;
      run_new.bytes[2] = y2;
      run_new.count    = (dec_emit && ok01) ? 3'd1 + {2'b00, p1} + {2'b00, p2} : 3'd0;
      fill_next   = (in_item.end_of_input || dec_full) ? 2'd0 : dec_cnt[1:0];
      halted_next = in_item.end_of_input ? 1'b0 : (halted || halt_set);
      store_we    = take && fill != 2'd3;
      store_idx   = fill;
    end
  end

  // hold the mode and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= b64c_pkg::MODE_ENCODE;
      fill   <= 2'd0;
      halted <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (accept) begin
        fill   <= fill_next;
        halted <= halted_next;
      end
    end
  end

  // store the group character or byte
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (accept && store_we && store_idx == 2'(i)) begin
        store[i] <= in_item.data_byte;
      end
    end
  end

  assign cur_last = cur_pos == (cur_run.count - 3'd1);
  assign cur_done = cur_valid && out_ready && cur_last;
  assign cur_free = !cur_valid || cur_done;

  // advance the draining run, refill from the pending run or the input
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cur_pos    <= 3'd0;
    end else begin
      if (pend_valid && cur_free) begin
        cur_run    <= pend_run;
        cur_valid  <= 1'b1;
        cur_pos    <= 3'd0;
        pend_valid <= 1'b0;
      end else if (accept && run_new.count != 3'd0 && cur_free) begin
        cur_run   <= run_new;
        cur_valid <= 1'b1;
        cur_pos   <= 3'd0;
      end else begin
        if (accept && run_new.count != 3'd0) begin
          pend_run   <= run_new;
          pend_valid <= 1'b1;
        end
        if (cur_done) begin
          cur_valid <= 1'b0;
        end else if (cur_valid && out_ready) begin
          cur_pos <= cur_pos + 3'd1;
        end
      end
    end
  end

  assign out_valid            = cur_valid;
  assign out_item.out_byte    = cur_run.bytes[cur_pos];
  assign out_item.last_in_run = cur_last;

`ifndef SYNTHESIS
  a_pend_behind_cur: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> cur_valid)
    else $error("pending run without a draining run");

  a_pos_in_run: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_run.count != 3'd0 && cur_pos < cur_run.count))
    else $error("output position outside its run");

  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.end_of_input) |=> (fill == 2'd0 && !halted))
    else $error("end of input left group state behind");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !out_ready) |=> (cur_valid && $stable(cur_pos)))
    else $error("draining run moved under stall");

  a_no_result_on_idle_decode: assert property (@(posedge clk) disable iff (rst)
    (mode == b64c_pkg::MODE_DECODE && accept && halted && !in_item.end_of_input)
      |-> run_new.count == 3'd0)
    else $error("halted decoder produced a result");
`endif

endmodule

`default_nettype wire

// ===== verif/base64_codec_unit_checker.sv =====
// Channel monitor, Base64 codec predictor and result comparison for base64_codec_unit.
`timescale 1ns / 1ps

module base64_codec_unit_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  b64c_pkg::in_item_t  in_item,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  b64c_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  due_count
);

  // predictor copy of the codec state
  logic       mode_q;
  logic [7:0] grp [3];
  logic [1:0] grp_fill;
  logic       halt_q;

  // results caused by the beat being predicted
  logic [7:0] run_buf [5];
  int         run_n;

  // characters and bytes still owed by the block, oldest first
  b64c_pkg::out_item_t due_q [$];
  b64c_pkg::out_item_t head_beat;

  initial begin
    fail_count = 0;
    due_count  = 0;
    mode_q     = b64c_pkg::MODE_ENCODE;
    grp_fill   = 2'd0;
    halt_q     = 1'b0;
    run_n      = 0;
    for (int k = 0; k < 3; k++) grp[k] = 8'h00;
  end

  // 6-bit value to alphabet character
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (w < 8'd26) begin
      return 8'h41 + w;
    end else if (w < 8'd52) begin
      return 8'h47 + w;
    end else if (w < 8'd62) begin
      return w - 8'd4;
    end else if (w == 8'd62) begin
      return 8'h2B;
    end
    return 8'h2F;
  endfunction

  // alphabet character to 6-bit value, -1 for anything outside the alphabet
  function automatic int sextet_of(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 65;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 71;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) + 4;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    return -1;
  endfunction

  // append one result, capped at the run length
  task automatic emit(input logic [7:0] b);
    if (run_n < b64c_pkg::RunLen) begin
      run_buf[run_n] = b;
      run_n++;
    end
  endtask

  // encode the first cnt stored bytes, padding the rest
  task automatic encode_group(input int cnt);
    logic [7:0] b0, b1, b2;
    b0 = grp[0];
    b1 = (cnt > 1) ? grp[1] : 8'h00;
    b2 = (cnt > 2) ? grp[2] : 8'h00;
    emit(alpha_char(b0[7:2]));
    emit(alpha_char({b0[1:0], b1[7:4]}));
    emit((cnt > 1) ? alpha_char({b1[3:0], b2[7:6]}) : b64c_pkg::PAD_CHAR);
    emit((cnt > 2) ? alpha_char(b2[5:0]) : b64c_pkg::PAD_CHAR);
  endtask

  // decode cnt characters; an invalid one halts the message
  task automatic decode_group(input logic [3:0][7:0] g, input int cnt);
    int s0, s1, s2, s3;
    bit bad;
    s2  = 0;
    bad = 1'b0;
    if (cnt >= 2) begin
      s0 = sextet_of(g[0]);
      s1 = sextet_of(g[1]);
      if (s0 < 0 || s1 < 0) begin
        halt_q = 1'b1;
      end else begin
        emit(8'((s0 << 2) | (s1 >> 4)));
        // a pad in position three counts as zero bits
        if (cnt >= 3 && g[2] != b64c_pkg::PAD_CHAR) begin
          s2 = sextet_of(g[2]);
          if (s2 < 0) begin
            halt_q = 1'b1;
            bad    = 1'b1;
          end else begin
            emit(8'(((s1 & 15) << 4) | (s2 >> 2)));
          end
        end
        if (!bad && cnt >= 4 && g[3] != b64c_pkg::PAD_CHAR) begin
          s3 = sextet_of(g[3]);
          if (s3 < 0) begin
            halt_q = 1'b1;
          end else begin
            emit(8'(((s2 & 3) << 6) | s3));
          end
        end
      end
    end
  endtask

  // advance the codec by one input beat and queue what it owes
  task automatic codec_step(input b64c_pkg::in_item_t it);
    int f;
    run_n = 0;
    f     = int'(grp_fill);
    if (mode_q == b64c_pkg::MODE_ENCODE) begin
      if (it.has_byte) begin
        if (f > 2) f = 2;
        grp[f] = it.data_byte;
        f++;
        if (f == 3) begin
          encode_group(3);
          f = 0;
        end
      end
      if (it.end_of_input) begin
        if (f > 0) encode_group(f);
        emit(b64c_pkg::NEWLINE_CHAR);
        f      = 0;
        halt_q = 1'b0;
      end
    end else begin
      // drop characters while halted
      if (it.has_byte && !halt_q) begin
        if (f == 3) begin
          decode_group({it.data_byte, grp[2], grp[1], grp[0]}, 4);
          f = 0;
        end else begin
          grp[f] = it.data_byte;
          f++;
        end
      end
      if (it.end_of_input) begin
        if (!halt_q && f > 0) decode_group({8'h00, grp[2], grp[1], grp[0]}, f);
        f      = 0;
        halt_q = 1'b0;
      end
    end
    grp_fill = 2'(f);
    for (int k = 0; k < run_n; k++) begin
      head_beat.out_byte    = run_buf[k];
      head_beat.last_in_run = (k == run_n - 1);
      due_q.push_back(head_beat);
    end
  endtask

  // watch both channels and the mode register
  always @(posedge clk) begin
    if (rst) begin
      mode_q   = b64c_pkg::MODE_ENCODE;
      grp_fill = 2'd0;
      halt_q   = 1'b0;
      due_q.delete();
    end else begin
      // compare each output beat with the oldest owed result
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("out_byte: expected nothing, actual %02h", out_item.out_byte);
          fail_count++;
        end else begin
          head_beat = due_q.pop_front();
          if (out_item.out_byte !== head_beat.out_byte) begin
            $error("out_byte: expected %02h, actual %02h",
                   head_beat.out_byte, out_item.out_byte);
            fail_count++;
          end
          if (out_item.last_in_run !== head_beat.last_in_run) begin
            $error("last_in_run: expected %0b, actual %0b",
                   head_beat.last_in_run, out_item.last_in_run);
            fail_count++;
          end
        end
      end
      // the beat taken at this edge still sees the old mode
      if (in_valid && in_ready) codec_step(in_item);
      if (cfg_we) mode_q = cfg_wdata;
    end
    due_count = due_q.size();
  end

endmodule

// ===== verif/base64_codec_unit_tb.sv =====
// Stimulus, clock, reset and verdict for the base64_codec_unit testbench.
`timescale 1ns / 1ps

module base64_codec_unit_tb;

  localparam int CycleLimit = 200000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  b64c_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  b64c_pkg::out_item_t out_item;

  int                 fail_count;
  int                 due_count;
  int                 cycle_count = 0;
  int                 burst_left  = 1;
  int                 phase_beats = 0;
  logic [7:0]         rx_tick     = 8'd0;
  b64c_pkg::in_item_t msg_q [$];

  base64_codec_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  base64_codec_unit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("base64_codec_unit: mismatch");
      $finish;
    end
  end

  // receiver back-pressure: free flow, coin toss, one in four, light stalls
  always @(negedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    case (rx_tick[7:6])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 1);
      2'd2: out_ready <= (rx_tick[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic b64c_pkg::in_item_t beat(input logic [7:0] d, input logic h,
                                              input logic e);
    b64c_pkg::in_item_t it;
    it.data_byte    = d;
    it.has_byte     = h;
    it.end_of_input = e;
    return it;
  endfunction

  function automatic logic [7:0] any_symbol();
    return b64c_pkg::enc_char(6'($urandom_range(0, 63)));
  endfunction

  // offer one beat and hold it until taken; end the burst with a random gap
  task automatic push_beat(input b64c_pkg::in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // send the queued message and count the beats that matter
  task automatic send_message();
    foreach (msg_q[i]) begin
      if (msg_q[i].has_byte || msg_q[i].end_of_input) phase_beats++;
      push_beat(msg_q[i]);
    end
    msg_q.delete();
  endtask

  // drop valid, drain owed results, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_text(input string s, input bit with_end);
    int k;
    for (k = 0; k < s.len(); k++) begin
      msg_q.push_back(beat(8'(s[k]), 1'b1, with_end && (k == s.len() - 1)));
    end
  endtask

  // add one character, now and then behind a beat the block ignores
  task automatic push_char(input logic [7:0] c);
    if ($urandom_range(0, 19) == 0) begin
      msg_q.push_back(beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
    end
    msg_q.push_back(beat(c, 1'b1, 1'b0));
  endtask

  // end the message on its last byte or with a bare marker
  task automatic close_message();
    b64c_pkg::in_item_t tail;
    if (msg_q.size() > 0 && msg_q[msg_q.size() - 1].has_byte &&
        $urandom_range(0, 1) == 1) begin
      tail = msg_q.pop_back();
      tail.end_of_input = 1'b1;
      msg_q.push_back(tail);
    end else begin
      msg_q.push_back(beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end
  endtask

  // raw bytes for encoding, mostly short with the odd long one
  task automatic build_byte_message();
    int len, k;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 7);
    for (k = 0; k < len; k++) push_char(8'($urandom_range(0, 255)));
    close_message();
  endtask

  // Base64 text, mostly well formed with random content, some corrupted
  task automatic build_text_message();
    int groups, shape, k, pos;
    b64c_pkg::in_item_t hit;
    groups = $urandom_range(0, 3);
    for (k = 0; k < 4 * groups; k++) push_char(any_symbol());
    shape = $urandom_range(0, 9);
    case (shape)
      0: begin
        push_char(any_symbol());
        push_char(any_symbol());
        push_char(b64c_pkg::PAD_CHAR);
        push_char(b64c_pkg::PAD_CHAR);
      end
      1: begin
        for (k = 0; k < 3; k++) push_char(any_symbol());
        push_char(b64c_pkg::PAD_CHAR);
      end
      2: begin
        // pad in position three only, fourth still decoded
        push_char(any_symbol());
        push_char(any_symbol());
        push_char(b64c_pkg::PAD_CHAR);
        push_char(any_symbol());
      end
      3: begin
        for (k = $urandom_range(1, 3); k > 0; k--) push_char(any_symbol());
      end
      4: begin
        // corrupt one character, with more text behind it to be dropped
        for (k = 0; k < 4; k++) push_char(any_symbol());
        pos = $urandom_range(0, msg_q.size() - 1);
        hit = msg_q[pos];
        hit.data_byte = ($urandom_range(0, 2) == 0) ? b64c_pkg::PAD_CHAR
                                                    : 8'($urandom_range(0, 255));
        msg_q[pos] = hit;
        for (k = 0; k < 4; k++) push_char(any_symbol());
      end
      5: begin
        for (k = $urandom_range(1, 6); k > 0; k--) push_char(8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
    close_message();
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 24);

    // encode: byte extremes, full group, empty message, one- and two-byte tails
    set_mode(b64c_pkg::MODE_ENCODE);
    msg_q.push_back(beat(8'h00, 1'b1, 1'b0));
    msg_q.push_back(beat(8'hFF, 1'b1, 1'b0));
    msg_q.push_back(beat(8'h80, 1'b1, 1'b1));
    msg_q.push_back(beat(8'h00, 1'b0, 1'b1));
    msg_q.push_back(beat(8'h4D, 1'b1, 1'b1));
    msg_q.push_back(beat(8'h01, 1'b1, 1'b0));
    msg_q.push_back(beat(8'hFE, 1'b1, 1'b1));
    send_message();
    settle();

    // decode: full group, pad in position three, pad first, invalid third,
    // partial tail, NUL as data
    set_mode(b64c_pkg::MODE_DECODE);
    push_text("TWFu", 1'b1);
    push_text("QQ=B", 1'b1);
    push_text("=A", 1'b1);
    push_text("QU*AQQ", 1'b1);
    push_text("QUI", 1'b1);
    push_text("A", 1'b0);
    msg_q.push_back(beat(8'h00, 1'b1, 1'b1));
    send_message();
    settle();

    // random phases, alternating the mode
    for (ph = 0; ph < 4; ph++) begin
      set_mode(ph[0] ? b64c_pkg::MODE_DECODE : b64c_pkg::MODE_ENCODE);
      phase_beats = 0;
      while (phase_beats < 58) begin
        if (ph[0]) begin
          build_text_message();
        end else begin
          build_byte_message();
        end
        send_message();
      end
      settle();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("base64_codec_unit: match");
    end else begin
      $display("base64_codec_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/b64c_pkg.sv
rtl/core/base64_codec_unit.sv
verif/base64_codec_unit_checker.sv
verif/base64_codec_unit_tb.sv
